// File: rtl/ced_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_pkg
// Shared types and codes of the C string escape decoder.
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [2:0] ERR_NEWLINE  = 3'd0;
  localparam logic [2:0] ERR_DELIM    = 3'd1;
  localparam logic [2:0] ERR_DANGLING = 3'd2;
  localparam logic [2:0] ERR_HEX_WS   = 3'd3;
  localparam logic [2:0] ERR_BAD_NUM  = 3'd4;
  localparam logic [2:0] ERR_UNKNOWN  = 3'd5;

  localparam logic [7:0] DELIM_RESET = 8'd34;

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } ced_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [2:0]  error_code;
    logic [15:0] length;
    logic        last;
  } ced_res_t;

  // Pre-decoded source byte
  typedef struct packed {
    logic       at_end;
    logic [7:0] ch;
    logic       is_nl;
    logic       is_delim;
    logic       is_bslash;
    logic       is_sptab;
    logic       is_ws;
    logic       is_x;
    logic       is_89;
    logic       oct_ok;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       esc_ok;
    logic [7:0] esc_val;
  } ced_cls_t;

  typedef struct packed {
    logic [1:0] n;
    ced_res_t   r0;
    ced_res_t   r1;
  } ced_push_t;

endpackage

// File: rtl/ced_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_front
// Accepts source bytes, classifies them and queues them for the back end.
// Holds the delimiter register.
// ----------------------------------------------------------------------------
module ced_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ced_pkg::ced_in_t in_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_data_i,
  output logic             q_valid_o,
  output ced_pkg::ced_cls_t q_item_o,
  input  logic             q_pop_i
);
  import ced_pkg::*;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;

  logic [7:0] delim_q;
  ced_cls_t   cls;
  ced_cls_t   entry_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
    end else if (cfg_valid_i) begin
      delim_q <= cfg_data_i;
    end
  end

  always_comb begin
    cls           = '0;
    cls.at_end    = in_i.at_end;
    cls.ch        = in_i.ch;
    cls.is_nl     = in_i.ch == CH_NL;
    cls.is_delim  = in_i.ch == delim_q;
    cls.is_bslash = in_i.ch == CH_BSLASH;
    cls.is_sptab  = (in_i.ch == CH_SPACE) || (in_i.ch == CH_TAB);
    cls.is_ws     = (in_i.ch == CH_SPACE) || ((in_i.ch >= CH_TAB) && (in_i.ch <= CH_CR));
    cls.is_x      = in_i.ch == CH_X;
    cls.is_89     = (in_i.ch == "8") || (in_i.ch == "9");
    cls.oct_ok    = (in_i.ch >= "0") && (in_i.ch <= "7");
    if ((in_i.ch >= "0") && (in_i.ch <= "9")) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = in_i.ch[3:0];
    end else if ((in_i.ch >= "a") && (in_i.ch <= "f")) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(in_i.ch - "a" + 8'd10);
    end else if ((in_i.ch >= "A") && (in_i.ch <= "F")) begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(in_i.ch - "A" + 8'd10);
    end
    cls.esc_ok = 1'b1;
    unique case (in_i.ch)
      "0":     cls.esc_val = 8'h00;
      "a":     cls.esc_val = 8'h07;
      "b":     cls.esc_val = 8'h08;
      "f":     cls.esc_val = 8'h0C;
      "n":     cls.esc_val = 8'h0A;
      "r":     cls.esc_val = 8'h0D;
      "t":     cls.esc_val = 8'h09;
      "v":     cls.esc_val = 8'h0B;
      "\\":    cls.esc_val = 8'h5C;
      "\"":    cls.esc_val = 8'h22;
      default: cls.esc_ok  = 1'b0;
    endcase
  end

  assign in_ready_o = cnt_q != 2'd2;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = entry_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wp_q] <= cls;
  end

endmodule

// File: rtl/ced_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_back
// Escape state machine: runs one classified byte per cycle while space_ok_i is
// high, holds the numeric accumulator and byte count, emits up to two results.
// ----------------------------------------------------------------------------
module ced_back #(
  parameter int LENGTH_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  ced_pkg::ced_cls_t q_item_i,
  output logic              q_pop_o,
  input  logic              space_ok_i,
  output ced_pkg::ced_push_t push_o
);
  import ced_pkg::*;

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_ESC     = 7'b0000010,
    MODE_SKIPWS  = 7'b0000100,
    MODE_HEXFRST = 7'b0001000,
    MODE_HEX     = 7'b0010000,
    MODE_OCT     = 7'b0100000,
    MODE_ERR     = 7'b1000000
  } ced_mode_e;

  ced_mode_e              mode_q, mode_d;
  logic [63:0]            acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic                   take, plain;
  ced_res_t               r_v [2];
  logic [1:0]             n_v;

  function automatic ced_res_t mk_res(logic [1:0] kind, logic [7:0] b, logic [2:0] code,
                                      logic [LENGTH_BITS-1:0] cnt);
    ced_res_t                r;
    logic [LENGTH_BITS+15:0] ext;
    ext          = {16'd0, cnt};
    r.kind       = kind;
    r.out_byte   = b;
    r.error_code = code;
    r.length     = ext[15:0];
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] sat_inc(logic [LENGTH_BITS-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign take    = q_valid_i && space_ok_i;
  assign q_pop_o = take;

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    plain  = 1'b0;
    n_v    = 2'd0;
    r_v[0] = '0;
    r_v[1] = '0;
    if (take) begin
      if (q_item_i.at_end) begin
        unique case (mode_q)
          MODE_ERR: begin
          end
          MODE_ESC: begin
            r_v[0] = mk_res(KIND_ERR, 8'h00, ERR_DANGLING, cnt_d);
            n_v    = 2'd1;
          end
          MODE_HEXFRST: begin
            r_v[0] = mk_res(KIND_ERR, 8'h00, ERR_BAD_NUM, cnt_d);
            n_v    = 2'd1;
          end
          MODE_HEX, MODE_OCT: begin
            cnt_d  = sat_inc(cnt_d);
            r_v[0] = mk_res(KIND_BYTE, ovf_q ? 8'hFF : acc_q[7:0], 3'd0, cnt_d);
            r_v[1] = mk_res(KIND_END, 8'h00, 3'd0, cnt_d);
            n_v    = 2'd2;
          end
          default: begin
            r_v[0] = mk_res(KIND_END, 8'h00, 3'd0, cnt_d);
            n_v    = 2'd1;
          end
        endcase
        mode_d = MODE_IDLE;
        acc_d  = '0;
        ovf_d  = 1'b0;
        cnt_d  = '0;
      end else begin
        unique case (mode_q)
          MODE_ERR: begin
          end
          MODE_ESC: begin
            mode_d = MODE_IDLE;
            if (q_item_i.esc_ok) begin
              cnt_d  = sat_inc(cnt_d);
              r_v[0] = mk_res(KIND_BYTE, q_item_i.esc_val, 3'd0, cnt_d);
              n_v    = 2'd1;
            end else if (q_item_i.is_nl) begin
              mode_d = MODE_SKIPWS;
            end else if (q_item_i.is_x) begin
              mode_d = MODE_HEXFRST;
            end else if (q_item_i.oct_ok) begin
              acc_d  = {61'd0, q_item_i.ch[2:0]};
              ovf_d  = 1'b0;
              mode_d = MODE_OCT;
            end else begin
              r_v[0] = mk_res(KIND_ERR, 8'h00, q_item_i.is_89 ? ERR_BAD_NUM : ERR_UNKNOWN,
                              cnt_d);
              n_v    = 2'd1;
              mode_d = MODE_ERR;
            end
          end
          MODE_SKIPWS: begin
            plain = !q_item_i.is_sptab;
          end
          MODE_HEXFRST: begin
            if (q_item_i.is_ws || !q_item_i.hex_ok) begin
              r_v[0] = mk_res(KIND_ERR, 8'h00, q_item_i.is_ws ? ERR_HEX_WS : ERR_BAD_NUM,
                              cnt_d);
              n_v    = 2'd1;
              mode_d = MODE_ERR;
            end else begin
              acc_d  = {60'd0, q_item_i.hex_val};
              ovf_d  = 1'b0;
              mode_d = MODE_HEX;
            end
          end
          MODE_HEX, MODE_OCT: begin
            if ((mode_q == MODE_HEX) && q_item_i.hex_ok) begin
              ovf_d = ovf_q | (|acc_q[63:60]);
              acc_d = {acc_q[59:0], q_item_i.hex_val};
            end else if ((mode_q == MODE_OCT) && q_item_i.oct_ok) begin
              ovf_d = ovf_q | (|acc_q[63:61]);
              acc_d = {acc_q[60:0], q_item_i.ch[2:0]};
            end else begin
              cnt_d  = sat_inc(cnt_d);
              r_v[0] = mk_res(KIND_BYTE, ovf_q ? 8'hFF : acc_q[7:0], 3'd0, cnt_d);
              n_v    = 2'd1;
              acc_d  = '0;
              ovf_d  = 1'b0;
              plain  = 1'b1;
            end
          end
          default: begin
            plain = 1'b1;
          end
        endcase
        if (plain) begin
          mode_d = MODE_IDLE;
          if (q_item_i.is_nl) begin
            r_v[n_v[0]] = mk_res(KIND_ERR, 8'h00, ERR_NEWLINE, cnt_d);
            n_v         = n_v + 2'd1;
            mode_d      = MODE_ERR;
          end else if (q_item_i.is_delim) begin
            r_v[n_v[0]] = mk_res(KIND_ERR, 8'h00, ERR_DELIM, cnt_d);
            n_v         = n_v + 2'd1;
            mode_d      = MODE_ERR;
          end else if (q_item_i.is_bslash) begin
            mode_d = MODE_ESC;
          end else begin
            cnt_d       = sat_inc(cnt_d);
            r_v[n_v[0]] = mk_res(KIND_BYTE, q_item_i.ch, 3'd0, cnt_d);
            n_v         = n_v + 2'd1;
          end
        end
      end
      if (n_v == 2'd2) begin
        r_v[1].last = 1'b1;
      end else if (n_v == 2'd1) begin
        r_v[0].last = 1'b1;
      end
    end
    push_o.n  = n_v;
    push_o.r0 = r_v[0];
    push_o.r1 = r_v[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      ovf_q  <= ovf_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: rtl/ced_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_res_fifo
// Four-entry result queue: takes up to two results a cycle, sends one if ready.
// ----------------------------------------------------------------------------
module ced_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ced_pkg::ced_push_t push_i,
  output logic               space_ok_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ced_pkg::ced_res_t  out_o
);
  import ced_pkg::*;

  ced_res_t   entry_q [4];
  logic [1:0] wp_q, rp_q, wp1;
  logic [2:0] cnt_q;
  logic       pop;

  assign space_ok_o  = cnt_q <= 3'd2;
  assign out_valid_o = cnt_q != 3'd0;
  assign out_o       = entry_q[rp_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wp1         = wp_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + push_i.n;
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, push_i.n} - 3'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) entry_q[wp_q] <= push_i.r0;
    if (push_i.n == 2'd2) entry_q[wp1]  <= push_i.r1;
  end

endmodule

// File: rtl/c_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_escape_decoder
// Decodes a C string literal body byte by byte: escapes, numeric escapes,
// line splices and error detection.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  in      | in  | in_valid_i/in_ready_o   | in_i  (ch, at_end)
//  out     | out | out_valid_o/out_ready_i | out_o (kind, out_byte, error_code,
//          |     |                         |        length, last)
//  cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_data_i (delimiter)
//
// One request accepted per cycle while in_ready_o is high; its first result
// goes through the input queue and then the result queue. A request that
// closes a numeric escape can give two results; the output port sends one per
// cycle while out_ready_i is high, so the result port sets the sustained rate.
// A two-entry input queue and a four-entry result queue let either side stall
// on its own. No clearing pass after reset; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module c_escape_decoder #(
  parameter int LENGTH_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ced_pkg::ced_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ced_pkg::ced_res_t out_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i
);
  import ced_pkg::*;

  logic      q_valid, q_pop, space_ok;
  ced_cls_t  q_item;
  ced_push_t push;

  ced_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  ced_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  ced_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// File: rtl/ced_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ced_checker
// Port-level checks on the escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ced_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ced_pkg::ced_res_t out_o
);
  import ced_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.kind != KIND_ERR) |-> out_o.error_code == 3'd0)
    else $error("error code on a non-error result");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.kind != KIND_BYTE) |-> out_o.out_byte == 8'h00)
    else $error("data byte on a non-byte result");

  a_term_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_o.kind == KIND_END) || (out_o.kind == KIND_ERR)) |-> out_o.last)
    else $error("end or error result not marked last");

endmodule

bind c_escape_decoder ced_checker u_ced_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for c_escape_decoder. A scoreboard class tracks the
// decoder state for each accepted request and queues the result records it
// should produce. Every returned record is compared against that queue. The
// request stream mixes short directed strings with random literals: simple
// escapes, hex and octal runs, long runs that overflow, line splices and error
// tokens. Random stalls on both sides. The delimiter is reprogrammed between
// phases.
// ----------------------------------------------------------------------------
module testbench;
  import ced_pkg::*;

  localparam int          CYCLE_LIMIT = 1000000;
  localparam logic [15:0] LEN_MAX     = 16'hFFFF;

  typedef enum logic [2:0] {
    S_IDLE, S_ESC, S_SKIPWS, S_HEXFIRST, S_HEX, S_OCT, S_ERROR
  } dec_mode_e;

  class escape_scoreboard;
    logic [7:0]  delim;
    dec_mode_e   mode;
    logic [63:0] acc;
    bit          ovf;
    logic [15:0] count;
    ced_res_t    due_results[$];
    int          errors;

    function new();
      delim  = DELIM_RESET;
      errors = 0;
      clear_string();
    endfunction

    task report(string msg);
      if (errors < 100) $display("ERROR: %s", msg);
      errors++;
    endtask

    function void clear_string();
      mode  = S_IDLE;
      acc   = '0;
      ovf   = 1'b0;
      count = '0;
    endfunction

    function void put(logic [1:0] kind, logic [7:0] b, logic [2:0] code);
      ced_res_t r;
      r.kind       = kind;
      r.out_byte   = b;
      r.error_code = code;
      r.length     = count;
      r.last       = 1'b0;
      due_results.push_back(r);
    endfunction

    function void emit_byte(logic [7:0] b);
      if (count != LEN_MAX) count++;
      put(KIND_BYTE, b, 3'd0);
    endfunction

    function void raise_error(logic [2:0] code);
      put(KIND_ERR, 8'd0, code);
      mode = S_ERROR;
    endfunction

    function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    function void plain_byte(logic [7:0] c);
      mode = S_IDLE;
      if (c == "\n") raise_error(ERR_NEWLINE);
      else if (c == delim) raise_error(ERR_DELIM);
      else if (c == "\\") mode = S_ESC;
      else emit_byte(c);
    endfunction

    function void finish_number();
      emit_byte(ovf ? 8'hFF : acc[7:0]);
      acc  = '0;
      ovf  = 1'b0;
      mode = S_IDLE;
    endfunction

    function void add_digit(logic [3:0] d, int shift);
      if ((acc >> (64 - shift)) != 0) ovf = 1'b1;
      acc = (acc << shift) | 64'(d);
    endfunction

    function void escape_byte(logic [7:0] c);
      mode = S_IDLE;
      case (c)
        "0":  emit_byte(8'h00);
        "a":  emit_byte(8'h07);
        "b":  emit_byte(8'h08);
        "f":  emit_byte(8'h0C);
        "n":  emit_byte(8'h0A);
        "r":  emit_byte(8'h0D);
        "t":  emit_byte(8'h09);
        "v":  emit_byte(8'h0B);
        "\\": emit_byte(8'h5C);
        "\"": emit_byte(8'h22);
        "\n": mode = S_SKIPWS;
        "x":  mode = S_HEXFIRST;
        default: begin
          if (c >= "1" && c <= "7") begin
            acc  = 64'(c - "0");
            ovf  = 1'b0;
            mode = S_OCT;
          end else if (c == "8" || c == "9") begin
            raise_error(ERR_BAD_NUM);
          end else begin
            raise_error(ERR_UNKNOWN);
          end
        end
      endcase
    endfunction

    function void note_request(ced_in_t it);
      logic [7:0] c;
      int         h;
      int         n0;
      c  = it.ch;
      n0 = due_results.size();
      if (it.at_end) begin
        case (mode)
          S_ERROR:    ;
          S_ESC:      raise_error(ERR_DANGLING);
          S_HEXFIRST: raise_error(ERR_BAD_NUM);
          S_HEX, S_OCT: begin
            finish_number();
            put(KIND_END, 8'd0, 3'd0);
          end
          default:    put(KIND_END, 8'd0, 3'd0);
        endcase
        clear_string();
      end else begin
        case (mode)
          S_ERROR: ;
          S_ESC:   escape_byte(c);
          S_SKIPWS: begin
            if (c != " " && c != "\t") plain_byte(c);
          end
          S_HEXFIRST: begin
            h = hex_value(c);
            if (c == " " || (c >= 8'h09 && c <= 8'h0D)) raise_error(ERR_HEX_WS);
            else if (h < 0) raise_error(ERR_BAD_NUM);
            else begin
              acc  = 64'(h);
              ovf  = 1'b0;
              mode = S_HEX;
            end
          end
          S_HEX: begin
            h = hex_value(c);
            if (h >= 0) add_digit(4'(h), 4);
            else begin
              finish_number();
              plain_byte(c);
            end
          end
          S_OCT: begin
            if (c >= "0" && c <= "7") add_digit(4'(c - "0"), 3);
            else begin
              finish_number();
              plain_byte(c);
            end
          end
          default: plain_byte(c);
        endcase
      end
      if (due_results.size() > n0) due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    task check_result(ced_res_t got);
      ced_res_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
      if (got.error_code !== want.error_code)
        report($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
      if (got.length !== want.length)
        report($sformatf("length %0d, want %0d", got.length, want.length));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b", got.last, want.last));
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  ced_in_t  in_data   = '0;
  logic     out_ready = 1'b0;
  logic     cfg_valid = 1'b0;
  logic [7:0] cfg_data = '0;
  logic     in_ready_o;
  logic     out_valid_o;
  ced_res_t out_o;
  logic     cfg_ready_o;

  escape_scoreboard sb;
  int in_calm   = 0;
  int out_calm  = 0;
  int live_reqs = 0;
  int cycles    = 0;

  c_escape_decoder #(.LENGTH_BITS(16)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_i        (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(5, 30);
    return $urandom_range(0, 12);
  endfunction

  task automatic send_item(input ced_in_t it);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (sb.mode != S_ERROR) live_reqs++;
    sb.note_request(it);
  endtask

  task automatic send_byte(input logic [7:0] c);
    ced_in_t it;
    it.ch     = c;
    it.at_end = 1'b0;
    send_item(it);
  endtask

  task automatic send_end();
    ced_in_t it;
    it.ch     = 8'($urandom_range(0, 255));
    it.at_end = 1'b1;
    send_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_delimiter(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    sb.delim = v;
  endtask

  function automatic bit known_escape(logic [7:0] c);
    string codes;
    codes = "0abfnrtv\\\"\nx123456789";
    for (int i = 0; i < codes.len(); i++)
      if (codes[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] safe_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == "\n" || c == "\\" || c == sb.delim);
    return c;
  endfunction

  task automatic run_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("\\x4g");
    send_text("\\129");
    send_text("\\\n \tq");
    send_end();
    send_text("\\x");
    send_end();
    send_byte(8'h5C);
    send_end();
    send_byte(8'h22);
    send_end();
  endtask

  task automatic gen_string();
    string hexd;
    string simple;
    int    ntok;
    int    r;
    int    n;
    bit    failed;
    logic [7:0] c;
    hexd   = "0123456789abcdefABCDEF";
    simple = "0abfnrtv\\\"";
    ntok   = $urandom_range(0, 10);
    failed = 1'b0;
    for (int t = 0; t < ntok && !failed; t++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_byte(safe_byte());
      end else if (r < 55) begin
        send_byte("\\");
        send_byte(simple[$urandom_range(0, simple.len() - 1)]);
      end else if (r < 67) begin
        send_text("\\x");
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 4);
        repeat (n) send_byte(hexd[$urandom_range(0, 21)]);
      end else if (r < 77) begin
        send_byte("\\");
        send_byte(8'("1" + $urandom_range(0, 6)));
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 24) : $urandom_range(0, 3);
        repeat (n) send_byte(8'("0" + $urandom_range(0, 7)));
      end else if (r < 84) begin
        send_text("\\\n");
        repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 1) ? " " : "\t");
      end else if (r < 90) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        failed = 1'b1;
        case ($urandom_range(0, 7))
          0: send_byte("\n");
          1: send_byte(sb.delim);
          2: send_text($urandom_range(0, 1) ? "\\8" : "\\9");
          3: begin
            send_text("\\x");
            c = $urandom_range(0, 6) == 0 ? " " : 8'($urandom_range(9, 13));
            send_byte(c);
          end
          4: begin
            send_text("\\x");
            do c = 8'($urandom_range(0, 255));
            while (sb.hex_value(c) >= 0 || c == " " || (c >= 8'h09 && c <= 8'h0D));
            send_byte(c);
          end
          5: begin
            send_byte("\\");
            do c = 8'($urandom_range(0, 255)); while (known_escape(c));
            send_byte(c);
          end
          6: send_byte("\\");
          default: send_text("\\x");
        endcase
        if ($urandom_range(0, 1))
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    send_end();
  endtask

  task automatic run_random(input int n);
    live_reqs = 0;
    while (live_reqs < n) gen_string();
  endtask

  initial begin
    int       gap;
    ced_res_t got;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got = out_o;
      sb.check_result(got);
    end
  end

  initial begin
    logic [7:0] delims [7];
    delims = '{8'd34, 8'h00, 8'hFF, 8'h5C, 8'h27, 8'h00, 8'd34};
    delims[5] = 8'($urandom_range(0, 255));
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < 7; p++) begin
      if (p > 0) write_delimiter(delims[p]);
      run_directed();
      if (p == 1) begin
        run_random(30);
        wait_idle();
        run_random(30);
      end else begin
        run_random(60);
      end
      wait_idle();
    end
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ced_pkg.sv
rtl/ced_front.sv
rtl/ced_back.sv
rtl/ced_res_fifo.sv
rtl/c_escape_decoder.sv
rtl/ced_checker.sv
tb/sv/testbench.sv
